@@ rtl/assert_macros.svh @@
// assertion macros for the zigzag scan reorder block
// used by files that carry concurrent checks; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks held off while reset is low
`define ZSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checks held off while reset is low
`define ZSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/zsr_pkg.sv @@
// shared constants, types and helpers for the zigzag scan reorder block
// no dependencies
`timescale 1ns / 1ps

package zsr_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int DATA_W      = 32;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int SIZE_W      = 4;
  localparam int CFG_IDX_W   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // walker control from the sequencer
  typedef struct packed {
    logic start;
    logic step;
  } walk_ctl_t;

  // clamp a size register to 1..maxv
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/zsr_store.sv @@
// block buffer: one write port, one read port with registered read data
// depends on zsr_pkg
`timescale 1ns / 1ps

module zsr_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [zsr_pkg::ADDR_W-1:0] wr_addr,
  input  logic [zsr_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [zsr_pkg::ADDR_W-1:0] rd_addr,
  output logic [zsr_pkg::DATA_W-1:0] rd_data
);
  import zsr_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/zsr_walk.sv @@
// zigzag position walker: row, column, scan direction and buffer address
// one shared adder moves the address on each step; depends on zsr_pkg
`timescale 1ns / 1ps

module zsr_walk (
  input  logic                       clk,
  input  logic                       rst_n,
  input  zsr_pkg::walk_ctl_t         ctl,
  input  logic [zsr_pkg::SIZE_W-1:0] ncols,
  input  logic [zsr_pkg::ROW_W-1:0]  row_last,
  input  logic [zsr_pkg::COL_W-1:0]  col_last,
  output logic [zsr_pkg::ADDR_W-1:0] addr,
  output logic [zsr_pkg::ADDR_W-1:0] addr_next,
  output logic                       at_end
);
  import zsr_pkg::*;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              up_r, up_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] delta;
  logic [ADDR_W-1:0] ncols_a;

  assign ncols_a = ADDR_W'(ncols);

  // pick the move; direction flips on every edge step
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    up_nxt  = up_r;
    delta   = '0;
    if (up_r) begin
      if (col_r == col_last) begin
        row_nxt = row_r + ROW_W'(1);
        delta   = ncols_a;
        up_nxt  = 1'b0;
      end else if (row_r == '0) begin
        col_nxt = col_r + COL_W'(1);
        delta   = ADDR_W'(1);
        up_nxt  = 1'b0;
      end else begin
        row_nxt = row_r - ROW_W'(1);
        col_nxt = col_r + COL_W'(1);
        delta   = ADDR_W'(1) - ncols_a;
      end
    end else begin
      if (row_r == row_last) begin
        col_nxt = col_r + COL_W'(1);
        delta   = ADDR_W'(1);
        up_nxt  = 1'b1;
      end else if (col_r == '0) begin
        row_nxt = row_r + ROW_W'(1);
        delta   = ncols_a;
        up_nxt  = 1'b1;
      end else begin
        row_nxt = row_r + ROW_W'(1);
        col_nxt = col_r - COL_W'(1);
        delta   = ncols_a - ADDR_W'(1);
      end
    end
  end

  // shared address adder
  assign addr_nxt = addr_r + delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      up_r   <= 1'b1;
      addr_r <= '0;
    end else if (ctl.start) begin
      row_r  <= '0;
      col_r  <= '0;
      up_r   <= 1'b1;
      addr_r <= '0;
    end else if (ctl.step) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      up_r   <= up_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign addr      = addr_r;
  assign addr_next = addr_nxt;
  assign at_end    = (row_r == row_last) && (col_r == col_last);

endmodule

@@ rtl/zigzag_scan_reorder.sv @@
// zigzag scan reorder top level: size registers, load counter, sequencer
// depends on zsr_pkg, zsr_store, zsr_walk and assert_macros.svh
`timescale 1ns / 1ps
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  in      | in_valid, in_ready, in_element     | into block
//  out     | out_valid, out_ready, out_value,   | out of block
//          | out_last                           |
//  cfg     | cfg_we, cfg_index, cfg_wdata       | into block
//
//  loading accepts each valid item into the next buffer entry; the item
//  that completes the block is followed by a buffer fetch state, then one
//  result per cycle from the walker and the buffer read port while the
//  output side keeps up
//  reset sets both sizes to 8 and empties the load count; the buffer
//  itself is not cleared
//  a stalled result holds the walker and the read data; no input is taken
//  while a block is being emitted

`include "assert_macros.svh"

module zigzag_scan_reorder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [zsr_pkg::DATA_W-1:0] in_element,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [zsr_pkg::DATA_W-1:0] out_value,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [zsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zsr_pkg::SIZE_W-1:0]    cfg_wdata
);
  import zsr_pkg::*;

  localparam int PROD_W = 2 * SIZE_W;

  // one-hot sequencer states
  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // size registers
  logic [SIZE_W-1:0] rows_r, rows_nxt;
  logic [SIZE_W-1:0] cols_r, cols_nxt;
  logic [SIZE_W-1:0] nrows, ncols;
  logic [PROD_W-1:0] total;

  // load counter, never reaches the block size
  logic [ADDR_W-1:0] load_count_r, load_count_nxt;

  logic              in_fire;
  logic              out_fire;
  logic              block_done;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [ADDR_W-1:0] walk_addr;
  logic [ADDR_W-1:0] walk_addr_next;
  logic              walk_end;
  walk_ctl_t         walk_ctl;

  // clamp sizes into range
  assign nrows = eff_size(rows_r, SIZE_W'(MAX_ROWS));
  assign ncols = eff_size(cols_r, SIZE_W'(MAX_COLS));
  assign total = PROD_W'(nrows) * PROD_W'(ncols);

  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign block_done = in_fire && (PROD_W'(load_count_r) == total - PROD_W'(1));

  // configuration writes; any size write restarts the load
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_nxt = cfg_wdata;
        REG_COLS: cols_nxt = cfg_wdata;
        default: begin
          rows_nxt = rows_r;
          cols_nxt = cols_r;
        end
      endcase
    end
  end

  always_comb begin
    load_count_nxt = load_count_r;
    if (cfg_we) begin
      load_count_nxt = '0;
    end else if (block_done) begin
      load_count_nxt = '0;
    end else if (in_fire) begin
      load_count_nxt = load_count_r + ADDR_W'(1);
    end
  end

  // sequencer: load items, fetch the first entry, then walk one per result
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (block_done) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_fire && walk_end) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      rows_r       <= SIZE_W'(MAX_ROWS);
      cols_r       <= SIZE_W'(MAX_COLS);
      load_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      rows_r       <= rows_nxt;
      cols_r       <= cols_nxt;
      load_count_r <= load_count_nxt;
    end
  end

  // walker restarts on a completed block and steps on each taken result before the last
  assign walk_ctl.start = block_done;
  assign walk_ctl.step  = (state_r == S_EMIT) && out_fire && !walk_end;

  // fetch reads the corner; during emit the read follows the walker's move
  assign rd_en   = (state_r == S_FETCH) || walk_ctl.step;
  assign rd_addr = (state_r == S_FETCH) ? walk_addr : walk_addr_next;

  zsr_store u_store (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (load_count_r),
    .wr_data (in_element),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  zsr_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (walk_ctl),
    .ncols     (ncols),
    .row_last  (ROW_W'(nrows - SIZE_W'(1))),
    .col_last  (COL_W'(ncols - SIZE_W'(1))),
    .addr      (walk_addr),
    .addr_next (walk_addr_next),
    .at_end    (walk_end)
  );

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_EMIT);
  assign out_value = rd_data;
  assign out_last  = walk_end;

  // input and output sides never open together
  `ZSR_ASSERT_SAME(a_no_overlap, clk, rst_n, out_valid, !in_ready,
    "input ready while a result is shown")
  // a completed block goes through the fetch state first
  `ZSR_ASSERT_NEXT(a_fetch_after_load, clk, rst_n, block_done,
    !in_ready && !out_valid, "completed block did not enter fetch")
  // results stream without gaps until the flagged one
  `ZSR_ASSERT_NEXT(a_no_gap, clk, rst_n, out_fire && !out_last, out_valid,
    "gap in the result run")
  // the flagged result returns the block to loading
  `ZSR_ASSERT_NEXT(a_back_to_load, clk, rst_n, out_fire && out_last,
    in_ready && (load_count_r == '0), "block did not return to loading")

endmodule
